// ----- src/fdgh_pkg.sv -----
// ----------------------------------------------------------------------------
// fdgh_pkg
// Shared codes, quadrant type and direction remap for the grid halver.
// ----------------------------------------------------------------------------
package fdgh_pkg;

    localparam int DIR_W = 4;

    // configuration register indexes
    localparam logic CFG_FINE_COLUMNS = 1'b0;
    localparam logic CFG_FINE_ROWS    = 1'b1;

    // flow direction codes: void and those touched by the remap
    localparam logic [DIR_W-1:0] DIR_VOID = 4'd0;
    localparam logic [DIR_W-1:0] DIR_C1   = 4'd1;
    localparam logic [DIR_W-1:0] DIR_C2   = 4'd2;
    localparam logic [DIR_W-1:0] DIR_C3   = 4'd3;
    localparam logic [DIR_W-1:0] DIR_C4   = 4'd4;
    localparam logic [DIR_W-1:0] DIR_C5   = 4'd5;
    localparam logic [DIR_W-1:0] DIR_C6   = 4'd6;
    localparam logic [DIR_W-1:0] DIR_C7   = 4'd7;
    localparam logic [DIR_W-1:0] DIR_C8   = 4'd8;

    // bit0 = right column, bit1 = bottom row
    typedef enum logic [1:0] {
        QUAD_TL = 2'd0,
        QUAD_TR = 2'd1,
        QUAD_BL = 2'd2,
        QUAD_BR = 2'd3
    } quad_t;

    // diagonals along the block's outer edge fold back inward
    function automatic logic [DIR_W-1:0] remap_dir(quad_t q, logic [DIR_W-1:0] d);
        logic [DIR_W-1:0] r;
        r = d;
        case (q)
            QUAD_TL:
            begin
                if (d == DIR_C2) r = DIR_C1;
                if (d == DIR_C6) r = DIR_C7;
            end
            QUAD_TR:
            begin
                if (d == DIR_C4) r = DIR_C3;
                if (d == DIR_C8) r = DIR_C1;
            end
            QUAD_BL:
            begin
                if (d == DIR_C4) r = DIR_C5;
                if (d == DIR_C8) r = DIR_C7;
            end
            default:
            begin
                if (d == DIR_C2) r = DIR_C3;
                if (d == DIR_C6) r = DIR_C5;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- src/flow_direction_grid_halver_top.sv -----
// ----------------------------------------------------------------------------
// flow_direction_grid_halver_top
// Halves a raster flow-direction grid: each 2x2 fine block -> one coarse cell.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Content
// s_*       in   fine cell request: tdata = cell_direction, cell_accumulation
// m_*       out  coarse cell request: tdata = coarse_direction,
//                tlast = row_end, tuser = frame_end
// cfg_*     in   register write: 0 = fine_columns, 1 = fine_rows
//
// One fine cell per cycle unless stalled. Stage A takes the cell, steps the
// raster counters and issues the read of the top-row partial memory; stage B
// then folds the registered cell into its partial, writes the partial back
// or loads the output register. A coarse cell leaves through the stage B and
// output registers after its bottom-right cell is taken. A stall on m_tready
// holds both stages; s_tready follows the output register being free or
// drained. Reset clears counters and sizes (2x2); the partial memory is not
// cleared, every entry is written by a top row before a bottom row reads it.
//
module flow_direction_grid_halver_top
    import fdgh_pkg::*;
#(
    parameter int MAX_COARSE_COLUMNS = 256,
    parameter int ACC_BITS           = 24,
    localparam int S_DATA_W          = ((DIR_W + ACC_BITS + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,    // [3:0] cell_direction, next cell_accumulation

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // [3:0] coarse_direction
    output logic                m_tlast,    // row_end
    output logic                m_tuser,    // frame_end

    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int SLOT_W  = (MAX_COARSE_COLUMNS > 1) ? $clog2(MAX_COARSE_COLUMNS) : 1;
    localparam int ENTRY_W = 1 + DIR_W + ACC_BITS;   // {any, dir, acc}

    // ---------------- configuration ----------------
    logic [9:0]  fine_columns_reg;
    logic [15:0] fine_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fine_columns_reg <= 10'd2;
            fine_rows_reg    <= 16'd2;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FINE_COLUMNS)
                fine_columns_reg <= cfg_data[9:0];
            else
                fine_rows_reg <= cfg_data;
        end
    end

    // ---------------- stage A: raster position ----------------
    logic [9:0]        col_reg, col_next;
    logic [15:0]       row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              adv;
    logic              accept;
    logic              a_in_area;
    quad_t             a_quad;
    logic [DIR_W-1:0]  a_dir;
    logic [ACC_BITS-1:0] a_acc;
    logic              a_row_end;
    logic              a_frame_end;
    logic              col_wrap;
    logic              rd_en;

    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    assign a_in_area   = (col_reg[9:1] < fine_columns_reg[9:1]) &&
                         (row_reg[15:1] < fine_rows_reg[15:1]);
    assign a_quad      = quad_t'({row_reg[0], col_reg[0]});
    assign a_dir       = remap_dir(a_quad, s_tdata[DIR_W-1:0]);
    assign a_acc       = s_tdata[DIR_W +: ACC_BITS];
    assign a_row_end   = (col_reg[9:1] == (fine_columns_reg[9:1] - 9'd1));
    assign a_frame_end = a_row_end && (row_reg[15:1] == (fine_rows_reg[15:1] - 15'd1));
    assign col_wrap    = ({1'b0, col_reg} + 11'd1) >= {1'b0, fine_columns_reg};
    assign rd_en       = accept && a_in_area && (a_quad == QUAD_BL);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next  = 10'd0;
                slot_next = '0;
                row_next  = (({1'b0, row_reg} + 17'd1) >= {1'b0, fine_rows_reg}) ?
                            16'd0 : row_reg + 16'd1;
            end
            else
            begin
                col_next = col_reg + 10'd1;
                // slot tracks (col / 2) modulo the memory depth
                if (col_reg[0])
                    slot_next = (slot_reg == SLOT_W'(MAX_COARSE_COLUMNS - 1)) ?
                                '0 : slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // ---------------- stage B registers ----------------
    logic                b_valid_reg;
    quad_t               b_quad_reg;
    logic [SLOT_W-1:0]   b_slot_reg;
    logic [DIR_W-1:0]    b_dir_reg;
    logic [ACC_BITS-1:0] b_acc_reg;
    logic                b_row_end_reg;
    logic                b_frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= accept && a_in_area;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_quad_reg      <= a_quad;
            b_slot_reg      <= slot_reg;
            b_dir_reg       <= a_dir;
            b_acc_reg       <= a_acc;
            b_row_end_reg   <= a_row_end;
            b_frame_end_reg <= a_frame_end;
        end
    end

    // ---------------- partial memory ----------------
    logic [ENTRY_W-1:0] part_mem [MAX_COARSE_COLUMNS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            part_mem[b_slot_reg] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= part_mem[slot_reg];
            fwd_data_reg <= wr_data;
        end
    end

    // write landing on the slot being read this cycle: take the new value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else if (rd_en)
            fwd_hit_reg <= wr_en && (b_slot_reg == slot_reg);
    end

    // ---------------- stage B: fold ----------------
    logic [ENTRY_W-1:0] left_reg;
    logic [ENTRY_W-1:0] src;
    logic [ENTRY_W-1:0] folded;
    logic               b_fire;

    assign b_fire = adv && b_valid_reg;

    always_comb
    begin
        if (b_quad_reg == QUAD_TL)
            src = '0;
        else if (b_quad_reg == QUAD_BL)
            src = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        else
            src = left_reg;

        folded = src;
        if (b_acc_reg > src[ACC_BITS-1:0])
        begin
            folded[ACC_BITS-1:0]           = b_acc_reg;
            folded[ACC_BITS +: DIR_W]      = b_dir_reg;
        end
        if (b_dir_reg != DIR_VOID)
            folded[ENTRY_W-1] = 1'b1;
    end

    assign wr_en   = b_fire && (b_quad_reg == QUAD_TR);
    assign wr_data = folded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else if (b_fire && ((b_quad_reg == QUAD_TL) || (b_quad_reg == QUAD_BL)))
            left_reg <= folded;
    end

    // ---------------- output register ----------------
    logic             out_valid_reg;
    logic [DIR_W-1:0] out_dir_reg;
    logic             out_row_end_reg;
    logic             out_frame_end_reg;
    logic             out_load;

    assign adv      = !out_valid_reg || m_tready;
    assign out_load = b_fire && (b_quad_reg == QUAD_BR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= out_load;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_dir_reg       <= folded[ENTRY_W-1] ? folded[ACC_BITS +: DIR_W] : DIR_VOID;
            out_row_end_reg   <= b_row_end_reg;
            out_frame_end_reg <= b_frame_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_dir_reg};
    assign m_tlast  = out_row_end_reg;
    assign m_tuser  = out_frame_end_reg;

`ifndef ASSERT_OFF
    a_br_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && adv |=> out_valid_reg)
        else $error("bottom-right cell did not load a result");

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_frame_end_reg |-> out_row_end_reg)
        else $error("frame end without row end");

    a_forward_taken: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && wr_en && (b_slot_reg == slot_reg) |=> fwd_hit_reg)
        else $error("read of a slot being written was not forwarded");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flow-direction grid halver.
// A short table of hand-made 2x2 blocks with hand-written results comes first,
// then one full-width frame that fills every top-row slot, then random phases
// with size changes mid-frame checked by an in-bench predictor. Every coarse
// cell is checked. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
    import fdgh_pkg::*;

    localparam int ACC_W        = 24;
    localparam int COARSE_SLOTS = 256;
    localparam int S_W          = ((DIR_W + ACC_W + 7) / 8) * 8;
    localparam int RANDOM_CELLS = 1600;
    localparam int CALM_CELLS   = 150;    // tail of the run with no idling
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PRINT_CAP    = 50;

    // running best over the cells of a block seen so far
    typedef struct {
        logic [ACC_W-1:0] acc;
        logic [DIR_W-1:0] dir;
        bit               any;
    } best_t;

    typedef struct {
        logic [DIR_W-1:0] dir;
        bit               row_end;
        bit               frame_end;
    } coarse_t;

    // one row of the directed table; typed = expected result written by hand
    typedef struct {
        logic [DIR_W-1:0] dir;
        logic [ACC_W-1:0] acc;
        bit               typed;
        coarse_t          want;
    } probe_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [S_W-1:0]     s_tdata;    // [3:0] cell_direction, [27:4] cell_accumulation
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;    // [3:0] coarse_direction
    logic               m_tlast;    // row_end
    logic               m_tuser;    // frame_end
    logic               cfg_we;
    logic               cfg_index;
    logic [15:0]        cfg_data;

    // predictor state
    best_t              top_best [COARSE_SLOTS];
    best_t              left_best;
    int                 cur_col;
    int                 cur_row;
    logic [9:0]         fine_cols;
    logic [15:0]        fine_rows;

    coarse_t            coarse_due [$];
    int                 mismatches;
    int                 cycles;
    int                 sent;
    bit                 calm;

    flow_direction_grid_halver_top
    #(
        .MAX_COARSE_COLUMNS (COARSE_SLOTS),
        .ACC_BITS           (ACC_W)
    )
    u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d coarse cells pending",
                     cycles, coarse_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("mismatch @%0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // values read right after the edge are the ones the edge sampled
    always @(posedge clk)
    begin
        coarse_t exp_c;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (coarse_due.size() == 0)
                report_mismatch("unexpected coarse cell, direction",
                                int'(m_tdata[3:0]), -1);
            else
            begin
                exp_c = coarse_due.pop_front();
                if (m_tdata[3:0] !== exp_c.dir)
                    report_mismatch("coarse_direction", int'(m_tdata[3:0]),
                                    int'(exp_c.dir));
                if (m_tdata[7:4] !== 4'd0)
                    report_mismatch("tdata padding", int'(m_tdata[7:4]), 0);
                if (m_tlast !== exp_c.row_end)
                    report_mismatch("row_end", int'(m_tlast), int'(exp_c.row_end));
                if (m_tuser !== exp_c.frame_end)
                    report_mismatch("frame_end", int'(m_tuser), int'(exp_c.frame_end));
            end
        end
    end

    // receiver: ready runs of mixed length with stalls between, none when calm
    initial
    begin : ready_gen
        int run_len;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            if (!calm)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    // edge-running diagonals fold back into the block
    function automatic logic [DIR_W-1:0] fold_inward(quad_t q, logic [DIR_W-1:0] d);
        logic [DIR_W-1:0] r;
        r = d;
        case (d)
            DIR_C2: if (q == QUAD_TL) r = DIR_C1; else if (q == QUAD_BR) r = DIR_C3;
            DIR_C6: if (q == QUAD_TL) r = DIR_C7; else if (q == QUAD_BR) r = DIR_C5;
            DIR_C4: if (q == QUAD_TR) r = DIR_C3; else if (q == QUAD_BL) r = DIR_C5;
            DIR_C8: if (q == QUAD_TR) r = DIR_C1; else if (q == QUAD_BL) r = DIR_C7;
            default: r = d;
        endcase
        return r;
    endfunction

    // later cell wins only on a strictly greater count
    function automatic best_t take_cell(best_t b, logic [DIR_W-1:0] d, logic [ACC_W-1:0] a);
        if (a > b.acc)
        begin
            b.acc = a;
            b.dir = d;
        end
        if (d != DIR_VOID)
            b.any = 1'b1;
        return b;
    endfunction

    // advance the predictor by one fine cell; made = a coarse cell results
    task automatic halve_cell(input logic [DIR_W-1:0] d, input logic [ACC_W-1:0] a,
                              output bit made, output coarse_t c);
        int    col;
        int    row;
        int    ccols;
        int    crows;
        int    slot;
        quad_t q;
        logic [DIR_W-1:0] rd;
        best_t b;
        made  = 1'b0;
        c     = '{DIR_VOID, 1'b0, 1'b0};
        col   = cur_col;
        row   = cur_row;
        ccols = int'(fine_cols) >> 1;
        crows = int'(fine_rows) >> 1;
        if ((col >> 1) < ccols && (row >> 1) < crows)
        begin
            q    = quad_t'({row[0], col[0]});
            slot = (col >> 1) % COARSE_SLOTS;
            rd   = fold_inward(q, d);
            if (!col[0])
            begin
                b = '{'0, DIR_VOID, 1'b0};
                if (q == QUAD_BL)
                    b = top_best[slot];
                left_best = take_cell(b, rd, a);
            end
            else if (q == QUAD_TR)
                top_best[slot] = take_cell(left_best, rd, a);
            else
            begin
                b           = take_cell(left_best, rd, a);
                c.dir       = b.any ? b.dir : DIR_VOID;
                c.row_end   = ((col >> 1) == ccols - 1);
                c.frame_end = c.row_end && ((row >> 1) == crows - 1);
                made        = 1'b1;
            end
        end
        // raster wrap; a size of 0 wraps like 1
        if (col + 1 >= int'(fine_cols))
        begin
            cur_col = 0;
            cur_row = (row + 1 >= int'(fine_rows)) ? 0 : row + 1;
        end
        else
            cur_col = col + 1;
    endtask

    // one request on the slave side; returns at the accepting edge
    task automatic push_cell(input logic [DIR_W-1:0] d, input logic [ACC_W-1:0] a,
                             input bit typed, input coarse_t want);
        bit      made;
        coarse_t c;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_W - DIR_W - ACC_W){1'b0}}, a, d};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        halve_cell(d, a, made, c);
        if (typed)
            coarse_due.push_back(want);
        else if (made)
            coarse_due.push_back(c);
    endtask

    task automatic pause_sender(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // hold the sender until every coarse cell is out and the pipe is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (coarse_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // registers only change while the block is idle
    task automatic set_sizes(input bit wr_cols, input logic [15:0] cols_val,
                             input bit wr_rows, input logic [15:0] rows_val);
        wait_drained();
        if (wr_cols)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_FINE_COLUMNS;
            cfg_data  <= cols_val;
            @(posedge clk);
            fine_cols = cols_val[9:0];
        end
        if (wr_rows)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_FINE_ROWS;
            cfg_data  <= rows_val;
            @(posedge clk);
            fine_rows = rows_val;
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DIR_W-1:0] pick_dir();
        if ($urandom_range(0, 9) == 0)
            return DIR_W'($urandom_range(9, 15));
        return DIR_W'($urandom_range(0, 8));
    endfunction

    // low counts make ties common; full range covers every bit
    function automatic logic [ACC_W-1:0] pick_acc();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return ACC_W'($urandom_range(0, 3));
            5:       return ACC_W'($urandom_range(0, 255));
            default: return ACC_W'($urandom);
        endcase
    endfunction

    task automatic send_random(input bit steady);
        coarse_t none;
        none = '{DIR_VOID, 1'b0, 1'b0};
        calm = (sent >= RANDOM_CELLS - CALM_CELLS);
        if (!calm && !steady)
        begin
            if ($urandom_range(0, 199) == 0)
                wait_drained();
            else if ($urandom_range(0, 5) == 0)
                pause_sender($urandom_range(1, 18));
        end
        push_cell(pick_dir(), pick_acc(), 1'b0, none);
        sent++;
    endtask

    initial
    begin : stimulus
        probe_t      directed_cells [24];
        coarse_t     none;
        bit          steady;
        bit          wr_cols;
        bit          wr_rows;
        int          mode;
        int          phase_len;
        logic [15:0] cols_val;
        logic [15:0] rows_val;

        none = '{DIR_VOID, 1'b0, 1'b0};
        // reset size is 2x2: every fourth cell closes a one-cell frame
        directed_cells = '{
            // edge diagonal in top-left wins at max count; ties lose
            '{DIR_C2,  24'hFFFFFF, 1'b0, none},
            '{DIR_C8,  24'd5,      1'b0, none},
            '{DIR_C4,  24'd0,      1'b0, none},
            '{DIR_C6,  24'hFFFFFF, 1'b1, '{DIR_C1, 1'b1, 1'b1}},
            // no count above zero
            '{DIR_C1,  24'd0,      1'b0, none},
            '{DIR_C3,  24'd0,      1'b0, none},
            '{DIR_C5,  24'd0,      1'b0, none},
            '{DIR_C7,  24'd0,      1'b1, '{DIR_VOID, 1'b1, 1'b1}},
            // all void codes
            '{DIR_VOID, 24'hFFFFFF, 1'b0, none},
            '{DIR_VOID, 24'd1,      1'b0, none},
            '{DIR_VOID, 24'd7,      1'b0, none},
            '{DIR_VOID, 24'hFFFFFE, 1'b1, '{DIR_VOID, 1'b1, 1'b1}},
            // rising counts: bottom-right remap wins
            '{4'd15,   24'd1,      1'b0, none},
            '{DIR_C4,  24'd2,      1'b0, none},
            '{DIR_C8,  24'd3,      1'b0, none},
            '{DIR_C2,  24'd4,      1'b1, '{DIR_C3, 1'b1, 1'b1}},
            // bottom-left remap wins
            '{DIR_C6,  24'd10,     1'b0, none},
            '{DIR_C8,  24'd20,     1'b0, none},
            '{DIR_C4,  24'd30,     1'b0, none},
            '{DIR_C6,  24'd5,      1'b1, '{DIR_C5, 1'b1, 1'b1}},
            // void cell holds the top count, another cell is non-void
            '{DIR_VOID, 24'd100,   1'b0, none},
            '{4'd9,    24'd50,     1'b0, none},
            '{DIR_C2,  24'd100,    1'b0, none},
            '{DIR_C8,  24'd99,     1'b1, '{DIR_VOID, 1'b1, 1'b1}}
        };

        mismatches = 0;
        cycles     = 0;
        sent       = 0;
        calm       = 1'b0;
        cur_col    = 0;
        cur_row    = 0;
        fine_cols  = 10'd2;
        fine_rows  = 16'd2;
        left_best  = '{'0, DIR_VOID, 1'b0};
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_FINE_COLUMNS;
        cfg_data   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cells[i])
            push_cell(directed_cells[i].dir, directed_cells[i].acc,
                      directed_cells[i].typed, directed_cells[i].want);

        // widest frame first: writes every top-row slot, so later size
        // changes anywhere in a frame never read an unwritten slot
        set_sizes(1'b1, 16'd513, 1'b1, 16'd2);
        repeat (513 * 2) send_random(1'b0);

        while (sent < RANDOM_CELLS)
        begin
            mode = $urandom_range(0, 15);
            case (mode)
                0:       cols_val = 16'd0;
                1:       cols_val = 16'd1;
                2:       cols_val = 16'd513;
                3:       cols_val = 16'd512;
                default: cols_val = 16'($urandom_range(2, 12));
            endcase
            // stray bits above the 10-bit column field
            if ($urandom_range(0, 4) == 0)
                cols_val[15:10] = 6'($urandom);
            mode = $urandom_range(0, 11);
            case (mode)
                0:       rows_val = 16'd0;
                1:       rows_val = 16'd1;
                2:       rows_val = 16'd65535;
                default: rows_val = 16'($urandom_range(2, 10));
            endcase
            mode    = $urandom_range(0, 2);
            wr_cols = (mode != 1);
            wr_rows = (mode != 0);
            // the calm tail keeps its sizes so the sender never drains
            if (!calm)
                set_sizes(wr_cols, cols_val, wr_rows, rows_val);

            phase_len = $urandom_range(20, 110);
            steady    = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len && sent < RANDOM_CELLS; i++)
                send_random(steady);
        end

        wait_drained();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
